// File: hdl/assert_macros.svh
// assertion macros used by the rtl file tbf_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/tbf_pkg.sv
// shared types and constants of the triangle bounding box scan
`default_nettype none

package tbf_pkg;

    // input op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // vertices per triangle
    localparam int VERTEX_COUNT = 3;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // item class decided by the front
    typedef enum logic {
        ITEM_LOAD,
        ITEM_STEP
    } item_kind_t;

    // queue head control seen by the back
    typedef struct packed {
        logic       valid;
        item_kind_t kind;
    } queue_ctl_t;

    // back sequencer states
    typedef enum logic [1:0] {
        ST_READY,
        ST_MUL,
        ST_INIT
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/tbf_front.sv
// front part: accepts items, classifies them and queues them for the back
`default_nettype none

module tbf_front
    import tbf_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    op,
    input  wire logic [COORD_BITS-1:0]   vert_a_x,
    input  wire logic [COORD_BITS-1:0]   vert_a_y,
    input  wire logic [COORD_BITS-1:0]   vert_b_x,
    input  wire logic [COORD_BITS-1:0]   vert_b_y,
    input  wire logic [COORD_BITS-1:0]   vert_c_x,
    input  wire logic [COORD_BITS-1:0]   vert_c_y,
    output queue_ctl_t                   q_ctl,
    output logic [6*COORD_BITS-1:0]      q_data,
    input  wire logic                    q_pop
);

    localparam int DW = 6 * COORD_BITS;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_kind_t          kind_mem_reg [QUEUE_DEPTH];
    logic [DW-1:0]       data_mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                push;
    item_kind_t          in_kind;

    // classify the incoming item
    assign in_kind = (op == OP_STEP) ? ITEM_STEP : ITEM_LOAD;

    // queue full holds off the sender
    assign in_stall = (count_reg == CW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;

    // head of queue
    assign q_ctl.valid = (count_reg != '0);
    assign q_ctl.kind  = kind_mem_reg[rd_ptr_reg];
    assign q_data      = data_mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem_reg[wr_ptr_reg] <= in_kind;
            data_mem_reg[wr_ptr_reg] <= {vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                                         vert_c_x, vert_c_y};
        end
    end

endmodule

`default_nettype wire

// File: hdl/tbf_back.sv
// back part: box setup, incremental edge functions and pixel scan
`default_nettype none

`include "assert_macros.svh"

module tbf_back
    import tbf_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fill_enable,
    input  wire queue_ctl_t              q_ctl,
    input  wire logic [6*COORD_BITS-1:0] q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic                         covered,
    output logic                         last,
    output logic                         valid_res
);

    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int P = 2 * D;
    localparam int W = P + 1;
    localparam int NV = VERTEX_COUNT;
    localparam logic [2:0] MUL_LAST = 3'(2 * NV);

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [2:0]            cnt_reg;

    logic [C-1:0]          vx_reg [NV];
    logic [C-1:0]          vy_reg [NV];
    logic signed [D-1:0]   dx_reg [NV];
    logic signed [D-1:0]   dy_reg [NV];
    logic signed [W-1:0]   ecol_reg [NV];
    logic signed [W-1:0]   ecur_reg [NV];
    logic signed [P-1:0]   prod_reg;

    logic [C-1:0]          box_min_x_reg;
    logic [C-1:0]          box_max_x_reg;
    logic [C-1:0]          box_min_y_reg;
    logic [C-1:0]          box_max_y_reg;
    logic [C-1:0]          scan_x_reg;
    logic [C-1:0]          scan_y_reg;
    logic                  scan_active_reg;

    logic                  out_valid_reg;
    logic [C-1:0]          pixel_x_reg;
    logic [C-1:0]          pixel_y_reg;
    logic                  covered_reg;
    logic                  last_reg;
    logic                  valid_res_reg;

    logic [C-1:0]          ld_x [NV];
    logic [C-1:0]          ld_y [NV];
    logic [C-1:0]          ld_min_x;
    logic [C-1:0]          ld_max_x;
    logic [C-1:0]          ld_min_y;
    logic [C-1:0]          ld_max_y;

    logic                  out_free;
    logic                  pop_load;
    logic                  pop_step;
    logic                  scan_go;

    logic [1:0]            k_mul;
    logic [2:0]            acc_idx;
    logic [1:0]            k_acc;
    logic signed [D-1:0]   rel_x;
    logic signed [D-1:0]   rel_y;
    logic signed [D-1:0]   op_a;
    logic signed [D-1:0]   op_b;
    logic signed [W-1:0]   prod_ext;

    logic [C:0]            x_inc;
    logic [C:0]            y_inc;
    logic                  y_wrap;
    logic                  x_done;
    logic                  is_last;
    logic                  is_cov;
    logic                  all_nonneg;
    logic                  all_nonpos;
    logic                  scan_in_box;

    // unpack the queued vertices
    always_comb
    begin
        for (int k = 0; k < NV; k++)
        begin
            ld_x[k] = q_data[(2 * (NV - 1 - k) + 1) * C +: C];
            ld_y[k] = q_data[(2 * (NV - 1 - k)) * C +: C];
        end
    end

    // bounding box of the queued triangle
    always_comb
    begin
        ld_min_x = ld_x[0];
        ld_max_x = ld_x[0];
        ld_min_y = ld_y[0];
        ld_max_y = ld_y[0];
        for (int k = 1; k < NV; k++)
        begin
            if (ld_x[k] < ld_min_x) ld_min_x = ld_x[k];
            if (ld_x[k] > ld_max_x) ld_max_x = ld_x[k];
            if (ld_y[k] < ld_min_y) ld_min_y = ld_y[k];
            if (ld_y[k] > ld_max_y) ld_max_y = ld_y[k];
        end
    end

    // sequencer and queue pop
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_READY:
            begin
                if (q_ctl.valid)
                begin
                    if (q_ctl.kind == ITEM_LOAD)
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_MUL;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_READY;
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    assign pop_load = q_pop && (q_ctl.kind == ITEM_LOAD);
    assign pop_step = q_pop && (q_ctl.kind == ITEM_STEP);
    assign scan_go  = scan_active_reg && fill_enable;

    // start value products, one multiply per cycle
    assign k_mul   = (cnt_reg[2:1] == 2'd3) ? 2'd0 : cnt_reg[2:1];
    assign acc_idx = cnt_reg - 3'd1;
    assign k_acc   = (acc_idx[2:1] == 2'd3) ? 2'd0 : acc_idx[2:1];
    assign rel_x   = $signed({1'b0, vx_reg[k_mul]}) - $signed({1'b0, box_min_x_reg});
    assign rel_y   = $signed({1'b0, vy_reg[k_mul]}) - $signed({1'b0, box_min_y_reg});
    assign op_a    = cnt_reg[0] ? dx_reg[k_mul] : rel_x;
    assign op_b    = cnt_reg[0] ? rel_y : dy_reg[k_mul];
    assign prod_ext = {{(W - P){prod_reg[P-1]}}, prod_reg};

    // coverage and scan advance
    assign x_inc   = {1'b0, scan_x_reg} + 1'b1;
    assign y_inc   = {1'b0, scan_y_reg} + 1'b1;
    assign y_wrap  = (y_inc >= {1'b0, box_max_y_reg});
    assign x_done  = (x_inc >= {1'b0, box_max_x_reg});
    assign is_last = (x_inc == {1'b0, box_max_x_reg}) && (y_inc == {1'b0, box_max_y_reg});

    always_comb
    begin
        all_nonneg = 1'b1;
        all_nonpos = 1'b1;
        for (int k = 0; k < NV; k++)
        begin
            if (ecur_reg[k][W-1]) all_nonneg = 1'b0;
            if (!ecur_reg[k][W-1] && (ecur_reg[k] != '0)) all_nonpos = 1'b0;
        end
    end
    assign is_cov = all_nonneg || all_nonpos;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_READY;
            cnt_reg         <= '0;
            box_min_x_reg   <= '0;
            box_max_x_reg   <= '0;
            box_min_y_reg   <= '0;
            box_max_y_reg   <= '0;
            scan_x_reg      <= '0;
            scan_y_reg      <= '0;
            scan_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (pop_load)
            begin
                box_min_x_reg   <= ld_min_x;
                box_max_x_reg   <= ld_max_x;
                box_min_y_reg   <= ld_min_y;
                box_max_y_reg   <= ld_max_y;
                scan_x_reg      <= ld_min_x;
                scan_y_reg      <= ld_min_y;
                scan_active_reg <= 1'b0;
            end
            if (state_reg == ST_INIT)
            begin
                scan_active_reg <= (box_min_x_reg < box_max_x_reg) &&
                                   (box_min_y_reg < box_max_y_reg);
            end
            if (pop_step && scan_go)
            begin
                if (y_wrap)
                begin
                    scan_y_reg <= box_min_y_reg;
                    scan_x_reg <= x_inc[C-1:0];
                    if (x_done)
                    begin
                        scan_active_reg <= 1'b0;
                    end
                end
                else
                begin
                    scan_y_reg <= y_inc[C-1:0];
                end
            end
            // output register
            if (pop_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop_load)
        begin
            for (int k = 0; k < NV; k++)
            begin
                vx_reg[k] <= ld_x[k];
                vy_reg[k] <= ld_y[k];
                dx_reg[k] <= $signed({1'b0, ld_x[(k + 1) % NV]}) - $signed({1'b0, ld_x[k]});
                dy_reg[k] <= $signed({1'b0, ld_y[(k + 1) % NV]}) - $signed({1'b0, ld_y[k]});
            end
        end
        if (state_reg == ST_MUL)
        begin
            if (cnt_reg < MUL_LAST)
            begin
                prod_reg <= op_a * op_b;
            end
            if (cnt_reg != 3'd0)
            begin
                if (!acc_idx[0])
                begin
                    ecol_reg[k_acc] <= prod_ext;
                end
                else
                begin
                    ecol_reg[k_acc] <= ecol_reg[k_acc] - prod_ext;
                end
            end
        end
        if (state_reg == ST_INIT)
        begin
            for (int k = 0; k < NV; k++)
            begin
                ecur_reg[k] <= ecol_reg[k];
            end
        end
        if (pop_step && scan_go)
        begin
            for (int k = 0; k < NV; k++)
            begin
                if (y_wrap)
                begin
                    ecol_reg[k] <= ecol_reg[k] - {{(W - D){dy_reg[k][D-1]}}, dy_reg[k]};
                    ecur_reg[k] <= ecol_reg[k] - {{(W - D){dy_reg[k][D-1]}}, dy_reg[k]};
                end
                else
                begin
                    ecur_reg[k] <= ecur_reg[k] + {{(W - D){dx_reg[k][D-1]}}, dx_reg[k]};
                end
            end
        end
        // result payload
        if (pop_step)
        begin
            pixel_x_reg   <= scan_go ? scan_x_reg : '0;
            pixel_y_reg   <= scan_go ? scan_y_reg : '0;
            covered_reg   <= scan_go && is_cov;
            last_reg      <= scan_go && is_last;
            valid_res_reg <= scan_go;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign covered   = covered_reg;
    assign last      = last_reg;
    assign valid_res = valid_res_reg;

    // scan position lies inside the current box
    assign scan_in_box = (scan_x_reg >= box_min_x_reg) && (scan_x_reg < box_max_x_reg) &&
                         (scan_y_reg >= box_min_y_reg) && (scan_y_reg < box_max_y_reg);

    // checks
    `ASSERT_CLK(a_scan_in_box, clk, rst_n, scan_active_reg |-> scan_in_box, "scan position outside the box")
    `ASSERT_CLK(a_last_ends_scan, clk, rst_n, (pop_step && scan_go && is_last) |=> !scan_active_reg, "scan still active after last pixel")
    `ASSERT_CLK(a_init_follows_mul, clk, rst_n, (state_reg == ST_INIT) |-> ($past(state_reg) == ST_MUL), "setup entered without multiply pass")
    `ASSERT_NEVER(a_no_step_pop_busy, clk, rst_n, q_pop && (state_reg != ST_READY), "queue popped while setup runs")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, pop_step && out_valid_reg && out_stall, "pending result overwritten")

endmodule

`default_nettype wire

// File: hdl/triangle_bbox_fill_scan.sv
// top level of the triangle bounding box scan with edge function coverage
//
// input channel: in_valid / in_stall with op and three vertices. op load
// stores the triangle and starts a scan at the box minimum corner; it gives
// no result. op step gives one result: the next candidate pixel, its
// coverage flag, a last flag and valid_res (all zero when no scan runs or
// fill_enable is clear).
// output channel: out_valid / out_stall; a held result stays put while
// out_stall is high, and up to two more items wait in the input queue.
// config channel: cfg_valid / cfg_ready writes fill_enable; always ready.
// throughput: one step per cycle while out_stall is low and no load is in
// setup. a load occupies the back end for bbox setup, six start-value
// products on one shared multiplier and edge init, after which steps resume;
// each step then only adds edge increments. a step waits in the input queue,
// and its result is registered in the output register when it is popped.
// reset: queue empty, scan idle, fill_enable cleared, no result pending.
`default_nettype none

module triangle_bbox_fill_scan
    import tbf_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [COORD_BITS-1:0] vert_a_x,
    input  wire logic [COORD_BITS-1:0] vert_a_y,
    input  wire logic [COORD_BITS-1:0] vert_b_x,
    input  wire logic [COORD_BITS-1:0] vert_b_y,
    input  wire logic [COORD_BITS-1:0] vert_c_x,
    input  wire logic [COORD_BITS-1:0] vert_c_y,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       covered,
    output logic                       last,
    output logic                       valid_res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_data
);

    queue_ctl_t                  q_ctl;
    logic [6*COORD_BITS-1:0]     q_data;
    logic                        q_pop;
    logic                        fill_enable_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fill_enable_reg <= cfg_data;
        end
    end

    // front: accept, classify, queue
    tbf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .vert_a_x (vert_a_x),
        .vert_a_y (vert_a_y),
        .vert_b_x (vert_b_x),
        .vert_b_y (vert_b_y),
        .vert_c_x (vert_c_x),
        .vert_c_y (vert_c_y),
        .q_ctl    (q_ctl),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // back: setup and scan
    tbf_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fill_enable (fill_enable_reg),
        .q_ctl       (q_ctl),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .covered     (covered),
        .last        (last),
        .valid_res   (valid_res)
    );

endmodule

`default_nettype wire
